[design/mesd_pkg.sv]
// shared types, codes and pixel address decode for the module event stream decoder
`timescale 1ns / 1ps
`default_nettype none
package mesd_pkg;

    localparam int ROC_COUNT_BITS_DEF = 5;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW           = $clog2(QUEUE_DEPTH + 1);

    // word type codes, top three bits of a module word
    localparam logic [2:0] TYPE_PIX0 = 3'd0;
    localparam logic [2:0] TYPE_PIX1 = 3'd1;
    localparam logic [2:0] TYPE_ROC  = 3'd2;
    localparam logic [2:0] TYPE_H1   = 3'd4;
    localparam logic [2:0] TYPE_H0   = 3'd5;
    localparam logic [2:0] TYPE_T1   = 3'd6;
    localparam logic [2:0] TYPE_T0   = 3'd7;

    localparam logic [23:0] RAW_FILLER = 24'hffffff;

    // event error bits
    localparam logic [13:0] EVERR_ROC    = 14'h0001;
    localparam logic [13:0] EVERR_BAD_T1 = 14'h0100;
    localparam logic [13:0] EVERR_BAD_T0 = 14'h0200;
    localparam logic [13:0] EVERR_BAD_H1 = 14'h0400;
    localparam logic [13:0] EVERR_BAD_H0 = 14'h0800;

    localparam logic [10:0] PIXERR_ABORT = 11'h400;

    typedef enum logic [2:0] {
        PH_H0     = 3'd0,
        PH_H1     = 3'd1,
        PH_ROC_T0 = 3'd2,
        PH_PIX0   = 3'd3,
        PH_PIX1   = 3'd4,
        PH_T1     = 3'd5,
        PH_SKIP   = 3'd6,
        PH_T0ONLY = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_ROC   = 2'd1,
        KIND_EVENT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [6:0] x;
        logic [7:0] y;
        logic [7:0] ph;
        logic [7:0] err;
    } t_pix_dec;

    // results caused by one word, always delivered in slot order
    typedef struct packed {
        logic        pix_v;
        logic [4:0]  pix_idx;
        logic [11:0] pix_hdr;
        logic [6:0]  pix_x;
        logic [7:0]  pix_y;
        logic [7:0]  pix_ph;
        logic [10:0] pix_err;
        logic        roca_v;
        logic [4:0]  roca_idx;
        logic [11:0] roca_hdr;
        logic        roca_err;
        logic        rocb_v;
        logic [4:0]  rocb_idx;
        logic [11:0] rocb_hdr;
        logic        rocb_err;
        logic        ev_v;
        logic [4:0]  ev_cnt;
        logic [15:0] ev_hdr;
        logic [15:0] ev_trl;
        logic [13:0] ev_err;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  roc_index;
        logic [11:0] roc_header;
        logic        roc_error;
        logic [6:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [7:0]  pulse_height;
        logic [10:0] pixel_error;
        logic [15:0] event_header;
        logic [15:0] event_trailer;
        logic [13:0] event_error;
    } t_result;

    function automatic t_pix_dec mesd_decode(input logic [23:0] raw, input logic lin);
        t_pix_dec   d;
        logic [5:0] c;
        logic [5:0] t6;
        logic [8:0] rr;
        logic [2:0] c1;
        logic [2:0] c0;
        logic [2:0] r2;
        logic [2:0] r1;
        logic [2:0] r0;
        d.ph  = {raw[8:5], raw[3:0]};
        d.err = {raw[4], 7'h00};
        c1 = raw[23:21];
        c0 = raw[20:18];
        r2 = raw[17:15];
        r1 = raw[14:12];
        r0 = raw[11:9];
        if (lin) begin
            d.x = {1'b0, raw[23:21], raw[19:17]};
            d.y = {1'b0, raw[16:13], raw[11:9]};
            if (d.x >= 7'd52 || raw[12]) d.err[6] = 1'b1;
            if (d.y >= 8'd80 || raw[20]) d.err[5] = 1'b1;
        end else begin
            c  = {1'b0, c1, 2'b00} + {2'b00, c1, 1'b0} + {3'b000, c0};
            t6 = {1'b0, r2, 2'b00} + {2'b00, r2, 1'b0} + {3'b000, r1};
            rr = {1'b0, t6, 2'b00} + {2'b00, t6, 1'b0} + {6'b000000, r0};
            d.y = 8'd80 - rr[8:1];
            d.x = {c, rr[0]};
            d.err[4] = (c1 >= 3'd6);
            d.err[3] = (c0 >= 3'd6);
            d.err[2] = (r2 >= 3'd6);
            d.err[1] = (r1 >= 3'd6);
            d.err[0] = (r0 >= 3'd6);
            // row out of range: below zero or at 80
            if (rr[8:1] > 8'd80 || rr[8:1] == 8'd0) d.err[5] = 1'b1;
            if (d.x >= 7'd52) d.err[6] = 1'b1;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

[design/mesd_front.sv]
// front end: record parser, pixel decode and result bundling for each word
`timescale 1ns / 1ps
`default_nettype none
module mesd_front
    import mesd_pkg::*;
#(
    parameter int ROC_COUNT_BITS = ROC_COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [15:0] i_word,
    input  wire logic        i_end,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    output t_entry           o_entry,
    output logic             o_push
);

    t_phase                    r_phase,   n_phase;
    logic [13:0]               r_ev_err,  n_ev_err;
    logic [15:0]               r_hdr,     n_hdr;
    logic [7:0]                r_trl,     n_trl;
    logic [11:0]               r_roc_hdr, n_roc_hdr;
    logic                      r_roc_err, n_roc_err;
    logic [ROC_COUNT_BITS-1:0] r_roc_cnt, n_roc_cnt;
    logic [11:0]               r_fpw,     n_fpw;
    logic                      r_fwm,     n_fwm;
    logic                      r_lin;

    logic [2:0]  typ;
    logic [23:0] dec_raw;
    t_pix_dec    dec;
    t_entry      e;
    logic        ev_fill;

    function automatic logic [ROC_COUNT_BITS-1:0] sat_inc(
        input logic [ROC_COUNT_BITS-1:0] v
    );
        return (v == {ROC_COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    assign typ = i_word[15:13];
    // pixel words: second word now, or a first word closed by fill at record end
    assign dec_raw = (r_phase == PH_PIX1) ? {r_fpw, i_word[11:0]} : {i_word[11:0], 12'h000};
    assign dec = mesd_decode(dec_raw, r_lin);

    always_comb begin
        n_phase   = r_phase;
        n_ev_err  = r_ev_err;
        n_hdr     = r_hdr;
        n_trl     = r_trl;
        n_roc_hdr = r_roc_hdr;
        n_roc_err = r_roc_err;
        n_roc_cnt = r_roc_cnt;
        n_fpw     = r_fpw;
        n_fwm     = r_fwm;
        e         = '0;
        ev_fill   = 1'b0;

        unique case (r_phase)
            PH_H0: begin
                n_ev_err  = (typ != TYPE_H0) ? EVERR_BAD_H0 : 14'h0000;
                n_roc_cnt = '0;
                n_roc_err = 1'b0;
                n_roc_hdr = 12'h000;
                n_hdr     = {i_word[7:0], 8'h00};
                n_phase   = PH_H1;
            end
            PH_H1: begin
                if (typ != TYPE_H1) n_ev_err = n_ev_err | EVERR_BAD_H1;
                n_hdr[7:0] = i_word[7:0];
                n_phase    = PH_ROC_T0;
            end
            PH_ROC_T0: begin
                if (typ == TYPE_ROC) begin
                    n_roc_hdr = i_word[11:0];
                    n_roc_err = 1'b0;
                    n_phase   = PH_PIX0;
                end else begin
                    if (typ != TYPE_T0) n_ev_err = n_ev_err | EVERR_BAD_T0;
                    else                n_ev_err = n_ev_err | {i_word[12:8], 9'h000};
                    n_trl   = i_word[7:0];
                    n_phase = PH_T1;
                end
            end
            PH_PIX0: begin
                if (typ == TYPE_PIX0 || typ == TYPE_PIX1) begin
                    n_fwm   = (typ != TYPE_PIX0);
                    n_fpw   = i_word[11:0];
                    n_phase = PH_PIX1;
                end else begin
                    // any other word closes the roc
                    e.roca_v   = 1'b1;
                    e.roca_idx = 5'(r_roc_cnt);
                    e.roca_hdr = r_roc_hdr;
                    e.roca_err = r_roc_err;
                    if (r_roc_err) n_ev_err = n_ev_err | EVERR_ROC;
                    n_roc_cnt = sat_inc(r_roc_cnt);
                    if (typ == TYPE_ROC) begin
                        n_roc_hdr = i_word[11:0];
                        n_roc_err = 1'b0;
                        n_phase   = PH_PIX0;
                    end else begin
                        if (typ != TYPE_T0) n_ev_err = n_ev_err | EVERR_BAD_T0;
                        else                n_ev_err = n_ev_err | {i_word[12:8], 9'h000};
                        n_trl   = i_word[7:0];
                        n_phase = PH_T1;
                    end
                end
            end
            PH_PIX1: begin
                if (typ != TYPE_PIX1 && i_word[15]) begin
                    // aborted pixel, roc ends without flagging the event
                    e.pix_v    = 1'b1;
                    e.pix_idx  = 5'(r_roc_cnt);
                    e.pix_hdr  = r_roc_hdr;
                    e.pix_err  = PIXERR_ABORT;
                    e.roca_v   = 1'b1;
                    e.roca_idx = 5'(r_roc_cnt);
                    e.roca_hdr = r_roc_hdr;
                    e.roca_err = 1'b1;
                    n_roc_err  = 1'b1;
                    n_roc_cnt  = sat_inc(r_roc_cnt);
                    n_phase    = PH_T0ONLY;
                end else begin
                    e.pix_v   = (dec_raw != RAW_FILLER);
                    e.pix_idx = 5'(r_roc_cnt);
                    e.pix_hdr = r_roc_hdr;
                    e.pix_x   = dec.x;
                    e.pix_y   = dec.y;
                    e.pix_ph  = dec.ph;
                    e.pix_err = {1'b0, r_fwm, (typ != TYPE_PIX1), dec.err};
                    if (e.pix_v && e.pix_err != 11'h000) n_roc_err = 1'b1;
                    n_phase = PH_PIX0;
                end
            end
            PH_T1: begin
                if (typ != TYPE_T1) n_ev_err = n_ev_err | EVERR_BAD_T1;
                e.ev_v   = 1'b1;
                e.ev_cnt = 5'(r_roc_cnt);
                e.ev_hdr = r_hdr;
                e.ev_trl = {r_trl, i_word[7:0]};
                e.ev_err = n_ev_err;
                n_phase  = PH_SKIP;
            end
            PH_T0ONLY: begin
                if (typ != TYPE_T0) n_ev_err = n_ev_err | EVERR_BAD_T0;
                else                n_ev_err = n_ev_err | {i_word[12:8], 9'h000};
                n_trl   = i_word[7:0];
                n_phase = PH_T1;
            end
            PH_SKIP: begin
            end
        endcase

        // record ended early: the missing words are fill words of type three
        if (i_end) begin
            if (n_phase == PH_PIX1) begin
                e.pix_v   = 1'b1;
                e.pix_idx = 5'(n_roc_cnt);
                e.pix_hdr = n_roc_hdr;
                e.pix_x   = dec.x;
                e.pix_y   = dec.y;
                e.pix_ph  = dec.ph;
                e.pix_err = {1'b0, n_fwm, 1'b1, dec.err};
                n_roc_err = 1'b1;
                n_phase   = PH_PIX0;
            end
            case (n_phase) inside
                PH_PIX0: begin
                    e.rocb_v   = 1'b1;
                    e.rocb_idx = 5'(n_roc_cnt);
                    e.rocb_hdr = n_roc_hdr;
                    e.rocb_err = n_roc_err;
                    if (n_roc_err) n_ev_err = n_ev_err | EVERR_ROC;
                    n_roc_cnt = sat_inc(n_roc_cnt);
                    n_ev_err  = n_ev_err | EVERR_BAD_T0 | EVERR_BAD_T1;
                    n_trl     = 8'h00;
                    ev_fill   = 1'b1;
                end
                PH_H1: begin
                    n_ev_err = n_ev_err | EVERR_BAD_H1 | EVERR_BAD_T0 | EVERR_BAD_T1;
                    n_trl    = 8'h00;
                    ev_fill  = 1'b1;
                end
                PH_ROC_T0, PH_T0ONLY: begin
                    n_ev_err = n_ev_err | EVERR_BAD_T0 | EVERR_BAD_T1;
                    n_trl    = 8'h00;
                    ev_fill  = 1'b1;
                end
                PH_T1: begin
                    n_ev_err = n_ev_err | EVERR_BAD_T1;
                    ev_fill  = 1'b1;
                end
                default: begin
                end
            endcase
            if (ev_fill) begin
                e.ev_v   = 1'b1;
                e.ev_cnt = 5'(n_roc_cnt);
                e.ev_hdr = n_hdr;
                e.ev_trl = {n_trl, 8'h00};
                e.ev_err = n_ev_err;
            end
            n_phase = PH_H0;
        end
    end

    assign o_entry = e;
    assign o_push  = i_accept && (e.pix_v || e.roca_v || e.rocb_v || e.ev_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_H0;
            r_ev_err  <= '0;
            r_hdr     <= '0;
            r_trl     <= '0;
            r_roc_hdr <= '0;
            r_roc_err <= 1'b0;
            r_roc_cnt <= '0;
            r_fpw     <= '0;
            r_fwm     <= 1'b0;
            r_lin     <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase   <= n_phase;
                r_ev_err  <= n_ev_err;
                r_hdr     <= n_hdr;
                r_trl     <= n_trl;
                r_roc_hdr <= n_roc_hdr;
                r_roc_err <= n_roc_err;
                r_roc_cnt <= n_roc_cnt;
                r_fpw     <= n_fpw;
                r_fwm     <= n_fwm;
            end
            if (i_cfg_we) begin
                r_lin <= i_cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

[design/mesd_fifo.sv]
// short queue of result bundles between front and back end
`timescale 1ns / 1ps
`default_nettype none
module mesd_fifo
    import mesd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output logic        o_empty,
    output logic        o_full
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [QUEUE_CW-1:0] r_cnt;

    assign n_wptr  = (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr  = (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= n_wptr;
            if (i_pop)  r_rptr <= n_rptr;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

[design/mesd_back.sv]
// back end: expands one bundle into result items through the output register
`timescale 1ns / 1ps
`default_nettype none
module mesd_back
    import mesd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_entry,
    input  wire logic   i_empty,
    output logic        o_pop,
    input  wire logic   i_ready,
    output logic        o_valid,
    output logic        o_last,
    output t_result     o_res
);

    logic        r_valid;
    logic        r_last;
    t_result     r_res;
    logic [3:0]  r_done;
    logic [3:0]  pend;
    logic [3:0]  sel;
    logic [3:0]  rest;
    logic        load;
    t_result     res;

    // slots: pixel, first roc, second roc, event
    assign pend = {i_entry.ev_v, i_entry.rocb_v, i_entry.roca_v, i_entry.pix_v} & ~r_done;
    assign sel  = pend & (~pend + 4'd1);
    assign rest = pend & ~sel;
    assign load = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && (rest == 4'd0);

    always_comb begin
        res = '0;
        if (sel[0]) begin
            res.kind         = KIND_PIXEL;
            res.roc_index    = i_entry.pix_idx;
            res.roc_header   = i_entry.pix_hdr;
            res.pixel_x      = i_entry.pix_x;
            res.pixel_y      = i_entry.pix_y;
            res.pulse_height = i_entry.pix_ph;
            res.pixel_error  = i_entry.pix_err;
        end else if (sel[1]) begin
            res.kind       = KIND_ROC;
            res.roc_index  = i_entry.roca_idx;
            res.roc_header = i_entry.roca_hdr;
            res.roc_error  = i_entry.roca_err;
        end else if (sel[2]) begin
            res.kind       = KIND_ROC;
            res.roc_index  = i_entry.rocb_idx;
            res.roc_header = i_entry.rocb_hdr;
            res.roc_error  = i_entry.rocb_err;
        end else begin
            res.kind          = KIND_EVENT;
            res.roc_index     = i_entry.ev_cnt;
            res.event_header  = i_entry.ev_hdr;
            res.event_trailer = i_entry.ev_trl;
            res.event_error   = i_entry.ev_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= res;
            r_last <= (rest == 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 4'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_done  <= (rest == 4'd0) ? 4'd0 : (r_done | sel);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_res   = r_res;

endmodule
`default_nettype wire

[design/module_event_stream_decoder_unit.sv]
// top level of the module event stream decoder
//
// Takes one 16-bit module word per clock, record end on tlast, and produces pixel,
// roc-done and event-done items. The front end parses and decodes a word and queues
// the items it causes (one to three) as a bundle; a word is taken every clock while
// the four-bundle queue has room. The back end sends one item per clock from its
// output register while the output is ready, so a word's results leave in turn and
// the output port sets the sustained rate. Items pass through the queue and then the
// output register. A record that ends before its trailer is closed within the same
// cycle. The linear_addressing bit on the config channel selects linear pixel
// addressing (1) or base-six addressing (0); write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module module_event_stream_decoder_unit
    import mesd_pkg::*;
#(
    parameter int ROC_COUNT_BITS = ROC_COUNT_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [15:0]  i_s_axis_tdata,   // word
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // roc_index, roc_header, roc_error, pixel_x, pixel_y, pulse_height, pixel_error,
    // event_header, event_trailer, event_error, zero pad
    output logic [103:0]      o_m_axis_tdata,
    output logic [1:0]        o_m_axis_tuser,   // kind
    output logic              o_m_axis_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_data        // linear_addressing
);

    logic    accept;
    logic    push;
    logic    pop;
    logic    empty;
    logic    full;
    t_entry  fr_entry;
    t_entry  q_entry;
    t_result res;

    // nothing is taken while reset is held
    assign o_s_axis_tready = i_rst_n && !full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = i_rst_n;

    mesd_front #(
        .ROC_COUNT_BITS(ROC_COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_s_axis_tdata),
        .i_end      (i_s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_entry    (fr_entry),
        .o_push     (push)
    );

    mesd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (fr_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_empty (empty),
        .o_full  (full)
    );

    mesd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_entry),
        .i_empty (empty),
        .o_pop   (pop),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_last  (o_m_axis_tlast),
        .o_res   (res)
    );

    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tdata = {6'b000000, res.event_error, res.event_trailer, res.event_header,
                             res.pixel_error, res.pulse_height, res.pixel_y, res.pixel_x,
                             res.roc_error, res.roc_header, res.roc_index};

endmodule
`default_nettype wire

[verif/module_event_stream_decoder_unit_tb.sv]
// self-checking testbench for the module event stream decoder
`timescale 1ns / 1ps
module module_event_stream_decoder_unit_tb;
    import mesd_pkg::*;

    localparam logic [15:0] FILL_WORD      = 16'h6000;
    localparam int          ROC_LIMIT      = (1 << ROC_COUNT_BITS_DEF) - 1;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 10;
    localparam int          HOLD_CYCLES    = 64;
    localparam int          PHASE_WORDS    = 110;

    typedef struct packed {
        t_result res;
        logic    last;
    } decoded_item_t;

    // predicts the items of each accepted word and checks them in order
    class mesd_tracker;
        decoded_item_t pending_items[$];
        bit            lin_mode;
        t_phase        phase;
        logic [13:0]   ev_err;
        logic [15:0]   hdr_acc;
        logic [7:0]    trl_high;
        logic [11:0]   roc_hdr;
        bit            roc_err;
        int            roc_cnt;
        logic [11:0]   pix_first;
        bit            pix_first_bad;
        int            step_results;
        int            mismatches;
        int            seen_kind[3];

        function new();
            lin_mode      = 1'b0;
            phase         = PH_H0;
            ev_err        = '0;
            hdr_acc       = '0;
            trl_high      = '0;
            roc_hdr       = '0;
            roc_err       = 1'b0;
            roc_cnt       = 0;
            pix_first     = '0;
            pix_first_bad = 1'b0;
            mismatches    = 0;
            seen_kind     = '{0, 0, 0};
        endfunction

        function void push_result(t_result r);
            decoded_item_t d;
            if (step_results >= 3) return;
            d.res  = r;
            d.last = 1'b0;
            pending_items.insert(pending_items.size(), d);
            step_results++;
        endfunction

        function void emit_pixel(logic [6:0] x, logic [7:0] y, logic [7:0] ph,
                                 logic [10:0] err);
            t_result r;
            r = '0;
            r.kind         = KIND_PIXEL;
            r.roc_index    = 5'(roc_cnt);
            r.roc_header   = roc_hdr;
            r.pixel_x      = x;
            r.pixel_y      = y;
            r.pulse_height = ph;
            r.pixel_error  = err;
            push_result(r);
        endfunction

        function void close_roc(bit aborted);
            t_result r;
            r = '0;
            r.kind       = KIND_ROC;
            r.roc_index  = 5'(roc_cnt);
            r.roc_header = roc_hdr;
            r.roc_error  = roc_err;
            push_result(r);
            if (roc_err && !aborted) ev_err |= EVERR_ROC;
            if (roc_cnt < ROC_LIMIT) roc_cnt++;
        endfunction

        function void decode_pixel(logic [23:0] raw, logic [10:0] framing);
            int unsigned c1, c0, r2, r1, r0, rr, x;
            int          y;
            logic [10:0] err;
            logic [7:0]  ph;
            ph  = 8'((raw & 24'h0f) + ((raw >> 1) & 24'hf0));
            err = raw[4] ? 11'd128 : 11'd0;
            if (lin_mode) begin
                x = ((raw >> 17) & 24'h07) + ((raw >> 18) & 24'h38);
                y = int'(((raw >> 9) & 24'h07) + ((raw >> 10) & 24'h78));
                if (x >= 52 || raw[12]) err |= 11'd64;
                if (y >= 80 || raw[20]) err |= 11'd32;
            end else begin
                c1 = raw[23:21];
                c0 = raw[20:18];
                r2 = raw[17:15];
                r1 = raw[14:12];
                r0 = raw[11:9];
                if (c1 >= 6) err |= 11'd16;
                if (c0 >= 6) err |= 11'd8;
                if (r2 >= 6) err |= 11'd4;
                if (r1 >= 6) err |= 11'd2;
                if (r0 >= 6) err |= 11'd1;
                rr = (r2 * 6 + r1) * 6 + r0;
                y  = 80 - int'(rr / 2);
                if (y < 0 || y >= 80) err |= 11'd32;
                x = 2 * (c1 * 6 + c0) + (rr & 1);
                if (x >= 52) err |= 11'd64;
            end
            err |= framing;
            if (err != '0) roc_err = 1'b1;
            emit_pixel(7'(x), 8'(y), ph, err);
        endfunction

        function void take_trailer0(logic [15:0] v);
            if (v[15:13] != TYPE_T0) ev_err |= EVERR_BAD_T0;
            else ev_err[13:9] |= v[12:8];
            trl_high = v[7:0];
            phase    = PH_T1;
        endfunction

        function void open_roc(logic [15:0] v);
            roc_hdr = v[11:0];
            roc_err = 1'b0;
            phase   = PH_PIX0;
        endfunction

        function void parse_word(logic [15:0] v);
            logic [2:0]  wt;
            logic [10:0] framing;
            logic [23:0] raw;
            t_result     r;
            wt = v[15:13];
            case (phase)
                PH_H0: begin
                    ev_err  = '0;
                    roc_cnt = 0;
                    roc_err = 1'b0;
                    roc_hdr = '0;
                    if (wt != TYPE_H0) ev_err |= EVERR_BAD_H0;
                    hdr_acc = {v[7:0], 8'h00};
                    phase   = PH_H1;
                end
                PH_H1: begin
                    if (wt != TYPE_H1) ev_err |= EVERR_BAD_H1;
                    hdr_acc[7:0] = v[7:0];
                    phase        = PH_ROC_T0;
                end
                PH_ROC_T0: begin
                    if (wt == TYPE_ROC) open_roc(v);
                    else take_trailer0(v);
                end
                PH_PIX0: begin
                    if (wt <= TYPE_PIX1) begin
                        pix_first_bad = (wt != TYPE_PIX0);
                        pix_first     = v[11:0];
                        phase         = PH_PIX1;
                    end else begin
                        close_roc(1'b0);
                        if (wt == TYPE_ROC) open_roc(v);
                        else take_trailer0(v);
                    end
                end
                PH_PIX1: begin
                    if (wt != TYPE_PIX1 && v[15]) begin
                        // aborted pixel: ends the roc, next word is the trailer
                        roc_err = 1'b1;
                        emit_pixel('0, '0, '0, PIXERR_ABORT);
                        close_roc(1'b1);
                        phase = PH_T0ONLY;
                    end else begin
                        framing = (pix_first_bad ? 11'h200 : 11'h000) |
                                  ((wt != TYPE_PIX1) ? 11'h100 : 11'h000);
                        raw = {pix_first, v[11:0]};
                        if (raw != RAW_FILLER) decode_pixel(raw, framing);
                        phase = PH_PIX0;
                    end
                end
                PH_T1: begin
                    if (wt != TYPE_T1) ev_err |= EVERR_BAD_T1;
                    r = '0;
                    r.kind          = KIND_EVENT;
                    r.roc_index     = 5'(roc_cnt);
                    r.event_header  = hdr_acc;
                    r.event_trailer = {trl_high, v[7:0]};
                    r.event_error   = ev_err;
                    push_result(r);
                    phase = PH_SKIP;
                end
                PH_T0ONLY: take_trailer0(v);
                default: ;
            endcase
        endfunction

        function void take_word(logic [15:0] w, logic last);
            int n0, i;
            n0           = pending_items.size();
            step_results = 0;
            parse_word(w);
            if (last) begin
                // a short record is closed with fill words
                for (i = 0; i < 8 && phase != PH_SKIP; i++) parse_word(FILL_WORD);
                phase = PH_H0;
            end
            if (pending_items.size() > n0) pending_items[pending_items.size() - 1].last = 1'b1;
        endfunction

        function string show(t_result r, logic last);
            return $sformatf({"kind=%0d last=%0d roc=%0d hdr=%03h rerr=%0d x=%0d y=%0d ",
                              "ph=%0d perr=%03h evh=%04h evt=%04h everr=%04h"},
                             r.kind, last, r.roc_index, r.roc_header, r.roc_error,
                             r.pixel_x, r.pixel_y, r.pulse_height, r.pixel_error,
                             r.event_header, r.event_trailer, r.event_error);
        endfunction

        function void check_item(logic [1:0] tuser, logic [103:0] tdata, logic tlast);
            t_result       act;
            decoded_item_t e;
            act.kind          = t_kind'(tuser);
            act.roc_index     = tdata[4:0];
            act.roc_header    = tdata[16:5];
            act.roc_error     = tdata[17];
            act.pixel_x       = tdata[24:18];
            act.pixel_y       = tdata[32:25];
            act.pulse_height  = tdata[40:33];
            act.pixel_error   = tdata[51:41];
            act.event_header  = tdata[67:52];
            act.event_trailer = tdata[83:68];
            act.event_error   = tdata[97:84];
            if (pending_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %s", show(act, tlast));
                return;
            end
            e = pending_items.pop_front();
            if (e.res.kind <= KIND_EVENT) seen_kind[e.res.kind]++;
            if (act !== e.res || tlast !== e.last || tdata[103:98] !== '0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("item mismatch at %0t", $realtime);
                    $display("  expected %s", show(e.res, e.last));
                    $display("  actual   %s pad=%0h", show(act, tlast), tdata[103:98]);
                end
            end
        endfunction
    endclass

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_valid  = 1'b0;
    logic [15:0]  s_data   = '0;
    logic         s_last   = 1'b0;
    logic         m_ready  = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_data = 1'b0;
    wire          o_s_axis_tready;
    wire          o_m_axis_tvalid;
    wire [103:0]  o_m_axis_tdata;
    wire [1:0]    o_m_axis_tuser;
    wire          o_m_axis_tlast;
    wire          o_cfg_ready;

    mesd_tracker book = new();
    int send_idle_pct = 35;
    int recv_idle_pct = 72;
    int words_sent    = 0;
    int hold_ticket   = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    module_event_stream_decoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // output side: check accepted items, random or forced back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready)
                book.check_item(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [15:0] w, input logic last, input bit useful);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        s_last  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        book.take_word(w, last);
        if (useful) words_sent++;
    endtask

    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        while (book.pending_items.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic lin);
        cfg_valid <= 1'b1;
        cfg_data  <= lin;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        book.lin_mode = lin;
    endtask

    function automatic logic [23:0] random_raw(input bit lin);
        logic [23:0] raw;
        int          k;
        raw = 24'($urandom);
        if ($urandom_range(11) == 0) return RAW_FILLER;
        if (!lin) begin
            // keep most base-six digits legal
            for (k = 9; k < 24; k += 3)
                if ($urandom_range(4) != 0) raw[k +: 3] = 3'($urandom_range(5));
        end else if ($urandom_range(2) != 0) begin
            raw[12] = 1'b0;
            raw[20] = 1'b0;
        end
        return raw;
    endfunction

    task automatic send_random_record(input int n_rocs);
        logic [15:0] words[$];
        int          pix1_at[$];
        int          useful, style, i, j, n_pix, pick;
        logic [23:0] raw;
        words.insert(words.size(), {TYPE_H0, 13'($urandom)});
        words.insert(words.size(), {TYPE_H1, 13'($urandom)});
        for (i = 0; i < n_rocs; i++) begin
            words.insert(words.size(), {TYPE_ROC, 13'($urandom)});
            n_pix = (n_rocs > 8) ? $urandom_range(0, 1) : $urandom_range(0, 3);
            for (j = 0; j < n_pix; j++) begin
                raw = random_raw(book.lin_mode);
                words.insert(words.size(), {TYPE_PIX0, 1'($urandom), raw[23:12]});
                pix1_at.insert(pix1_at.size(), words.size());
                words.insert(words.size(), {TYPE_PIX1, 1'($urandom), raw[11:0]});
            end
        end
        words.insert(words.size(),
                     ($urandom_range(6) != 0) ? {TYPE_T0, 13'($urandom)} : 16'($urandom));
        words.insert(words.size(),
                     ($urandom_range(6) != 0) ? {TYPE_T1, 13'($urandom)} : 16'($urandom));
        useful = words.size();
        style  = $urandom_range(99);
        if (style < 58) begin
            // words after the trailer are ignored
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 3)) words.insert(words.size(), 16'($urandom));
        end else if (style < 70) begin
            pick = $urandom_range(1, words.size() - 1);
            while (words.size() > pick) void'(words.pop_back());
            useful = words.size();
        end else if (style < 80) begin
            if (pix1_at.size() != 0 && $urandom_range(1) == 0) begin
                pick = pix1_at[$urandom_range(pix1_at.size() - 1)];
                if ($urandom_range(1) == 0) words[pick - 1][13] = 1'b1;
                else words[pick][13] = 1'b0;
            end else begin
                words[$urandom_range(words.size() - 1)] = 16'($urandom);
            end
        end else if (style < 90) begin
            if (pix1_at.size() == 0) begin
                void'(words.pop_back());
                void'(words.pop_back());
                words.insert(words.size(), {TYPE_ROC, 13'($urandom)});
                words.insert(words.size(), {TYPE_PIX0, 13'($urandom)});
                pick = words.size();
                words.insert(words.size(), 16'h0000);
            end else begin
                pick = pix1_at[$urandom_range(pix1_at.size() - 1)];
            end
            while (words.size() > pick + 1) void'(words.pop_back());
            words[pick] = {3'($urandom_range(4, 7)), 13'($urandom)};
            words.insert(words.size(), {TYPE_T0, 13'($urandom)});
            words.insert(words.size(), {TYPE_T1, 13'($urandom)});
            useful = words.size();
        end else begin
            words.delete();
            repeat ($urandom_range(1, 6)) words.insert(words.size(), 16'($urandom));
            useful = words.size();
        end
        for (i = 0; i < words.size(); i++)
            send_word(words[i], i == words.size() - 1, i < useful);
    endtask

    initial begin
        int ph, rec_no, target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);

        // base-six: address extremes, filler pixel, full trailer status
        send_word(16'hbfff, 1'b0, 1'b1);
        send_word(16'h8000, 1'b0, 1'b1);
        send_word(16'h5abc, 1'b0, 1'b1);
        send_word(16'h0000, 1'b0, 1'b1);
        send_word(16'h2000, 1'b0, 1'b1);
        send_word(16'h1fff, 1'b0, 1'b1);
        send_word(16'h3e1f, 1'b0, 1'b1);
        send_word(16'h0fff, 1'b0, 1'b1);
        send_word(16'h2fff, 1'b0, 1'b1);
        send_word(16'hffaa, 1'b0, 1'b1);
        send_word(16'hc055, 1'b1, 1'b1);
        // aborted pixel followed by the trailer
        send_word(16'ha012, 1'b0, 1'b1);
        send_word(16'h8034, 1'b0, 1'b1);
        send_word(16'h4001, 1'b0, 1'b1);
        send_word(16'h0123, 1'b0, 1'b1);
        send_word(16'h8abc, 1'b0, 1'b1);
        send_word(16'he0f0, 1'b0, 1'b1);
        send_word(16'hdf0f, 1'b1, 1'b1);
        // one-word record with a bad header
        send_word(16'h1234, 1'b1, 1'b1);
        wait_idle(SETTLE_CYCLES);

        // linear: swapped pixel word types, record cut before its trailer
        write_mode(1'b1);
        send_word(16'ha000, 1'b0, 1'b1);
        send_word(16'h9fff, 1'b0, 1'b1);
        send_word(16'h5fff, 1'b0, 1'b1);
        send_word(16'h3fff, 1'b0, 1'b1);
        send_word(16'h1ffe, 1'b1, 1'b1);

        for (ph = 0; ph < 3; ph++) begin
            wait_idle(SETTLE_CYCLES);
            write_mode(ph != 1);
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 72 : 0;
            recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 35 : 0;
            target = words_sent + PHASE_WORDS;
            rec_no = 0;
            while (words_sent < target) begin
                if (ph == 2 && rec_no == 2) hold_ticket <= hold_ticket + 1;
                if (ph == 2 && rec_no == 7) wait_idle(0);
                // enough rocs to saturate the count
                if (ph != 0 && rec_no == 4) send_random_record(ROC_LIMIT + 2);
                else send_random_record($urandom_range(0, 4));
                rec_no++;
            end
        end
        wait_idle(SETTLE_CYCLES);

        $display("%0d words sent in base-six and linear modes, with back-pressure and gaps",
                 words_sent);
        $display("checked %0d pixel, %0d roc and %0d event items, %0d mismatches",
                 book.seen_kind[KIND_PIXEL], book.seen_kind[KIND_ROC],
                 book.seen_kind[KIND_EVENT], book.mismatches);
        if (book.mismatches == 0 && book.pending_items.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/mesd_pkg.sv
design/mesd_front.sv
design/mesd_fifo.sv
design/mesd_back.sv
design/module_event_stream_decoder_unit.sv
verif/module_event_stream_decoder_unit_tb.sv
